FILE: rtl/assert_macros.svh
// Shared assertion macros for the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on the rising clock edge, off during reset
`define ASSERT_AT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");

// Antecedent this cycle implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/tkss_pkg.sv
package tkss_pkg;

  localparam int unsigned SCORE_W  = 16;
  localparam int unsigned INDEX_W  = 10;
  localparam int unsigned TOPK_W   = 5;
  localparam int unsigned PADDR_W  = 3;
  localparam int unsigned PDATA_W  = 32;

  localparam logic [TOPK_W-1:0] TOPK_RESET = 5'd5;

  // word index of the top_k register
  localparam logic REG_TOP_K = 1'b0;

  typedef enum logic {
    ST_FILL,
    ST_DRAIN
  } state_e;

  typedef struct packed {
    logic               valid;
    logic [SCORE_W-1:0] score;
    logic [INDEX_W-1:0] cls;
  } entry_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic               insert;
    logic               shift;
    logic               clear;
    logic [SCORE_W-1:0] score;
    logic [INDEX_W-1:0] cls;
  } cell_ctrl_t;

endpackage

FILE: rtl/tkss_cell.sv
module tkss_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tkss_pkg::cell_ctrl_t ctrl_i,
  input  tkss_pkg::entry_t     prev_i,
  input  logic                 prev_take_i,
  input  tkss_pkg::entry_t     next_i,
  output tkss_pkg::entry_t     entry_o,
  output logic                 take_o
);

  logic                               valid_q, valid_d;
  logic [tkss_pkg::SCORE_W-1:0]       score_q, score_d;
  logic [tkss_pkg::INDEX_W-1:0]       cls_q, cls_d;

  // new entry ranks at or above this one (ties go to the later index)
  assign take_o = !valid_q || (score_q <= ctrl_i.score);

  always_comb begin
    valid_d = valid_q;
    score_d = score_q;
    cls_d   = cls_q;
    if (ctrl_i.clear) begin
      valid_d = 1'b0;
    end else if (ctrl_i.insert && take_o) begin
      if (prev_take_i) begin
        valid_d = prev_i.valid;
        score_d = prev_i.score;
        cls_d   = prev_i.cls;
      end else begin
        valid_d = 1'b1;
        score_d = ctrl_i.score;
        cls_d   = ctrl_i.cls;
      end
    end else if (ctrl_i.shift) begin
      valid_d = next_i.valid;
      score_d = next_i.score;
      cls_d   = next_i.cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    score_q <= score_d;
    cls_q   <= cls_d;
  end

  assign entry_o = '{valid: valid_q, score: score_q, cls: cls_q};

endmodule

FILE: rtl/top_k_score_select.sv
// Streaming top-k selection over a vector of class scores.
// Input channel: score_i with vector_last_i, under in_valid_i / in_stall_o.
// The class index of a score is its position in the vector; positions at or
// beyond MAX_CHANNELS are not ranked. A row of MAX_K cells keeps the best
// entries sorted; each accepted score is compared in every cell at once and
// the row shifts down by one below the insertion point, so one score is
// taken per cycle while a vector streams in.
// On the transfer marked vector_last the block drains: the head cell moves
// to the output register and the row shifts up, one entry per cycle while
// the output is not stalled, best first, min(top_k, filled) entries with a
// top_k of 0 taken as 1, rank_last_o on the final one. While the drain runs
// in_stall_o is high, so no score is taken until it ends. A stall on the
// output channel holds the output register and pauses the drain. The row is
// cleared once the final entry is loaded. Reset empties the row, clears the
// output valid flag and sets top_k to 5. top_k is written over the APB port
// at word address 0.
module top_k_score_select #(
  parameter int unsigned MAX_K        = 16,
  parameter int unsigned MAX_CHANNELS = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tkss_pkg::PADDR_W-1:0]   paddr,
  input  logic [tkss_pkg::PDATA_W-1:0]   pwdata,
  output logic [tkss_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [tkss_pkg::SCORE_W-1:0]   score_i,
  input  logic                           vector_last_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [tkss_pkg::INDEX_W-1:0]   class_index_o,
  output logic [tkss_pkg::SCORE_W-1:0]   class_score_o,
  output logic                           rank_last_o
);

  localparam int unsigned CNT_W = $clog2(MAX_K + 1);
  localparam int unsigned POS_W = $clog2(MAX_CHANNELS + 1);
  localparam int unsigned CMP_W = (CNT_W > tkss_pkg::TOPK_W) ? CNT_W : tkss_pkg::TOPK_W;

  tkss_pkg::state_e                state_q, state_d;
  logic [tkss_pkg::TOPK_W-1:0]     top_k_q;
  logic [POS_W-1:0]                pos_q, pos_d;
  logic [CNT_W-1:0]                filled_q, filled_d;
  logic [CNT_W-1:0]                remain_q, remain_d;
  logic                            out_valid_q, out_valid_d;
  logic [tkss_pkg::INDEX_W-1:0]    out_cls_q;
  logic [tkss_pkg::SCORE_W-1:0]    out_score_q;
  logic                            out_last_q;

  logic                            in_xfer, cfg_wr, do_insert, out_free, load;
  logic [CNT_W-1:0]                filled_ins;
  logic [CMP_W-1:0]                k_ext, k_clamp, fill_ext, n_ext;
  tkss_pkg::cell_ctrl_t            ctrl;
  tkss_pkg::entry_t                entry [MAX_K];
  logic                            take  [MAX_K];

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[2] == tkss_pkg::REG_TOP_K);
  assign prdata = (paddr[2] == tkss_pkg::REG_TOP_K) ?
                  tkss_pkg::PDATA_W'(top_k_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_k_q <= tkss_pkg::TOPK_RESET;
    end else if (cfg_wr) begin
      top_k_q <= pwdata[tkss_pkg::TOPK_W-1:0];
    end
  end

  assign in_stall_o = (state_q == tkss_pkg::ST_DRAIN);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign do_insert  = in_xfer && (pos_q < POS_W'(MAX_CHANNELS));
  assign out_free   = !out_valid_q || !out_stall_i;
  assign load       = (state_q == tkss_pkg::ST_DRAIN) && out_free;

  assign filled_ins = (filled_q < CNT_W'(MAX_K)) ? filled_q + CNT_W'(1) : filled_q;

  // clamp top_k to 1..MAX_K and limit by the entries kept
  always_comb begin
    k_ext    = CMP_W'(top_k_q);
    fill_ext = CMP_W'(do_insert ? filled_ins : filled_q);
    if (k_ext == '0) begin
      k_clamp = CMP_W'(1);
    end else if (k_ext > CMP_W'(MAX_K)) begin
      k_clamp = CMP_W'(MAX_K);
    end else begin
      k_clamp = k_ext;
    end
    n_ext = (fill_ext < k_clamp) ? fill_ext : k_clamp;
  end

  always_comb begin
    ctrl.insert = do_insert;
    ctrl.shift  = load;
    ctrl.clear  = load && (remain_q == CNT_W'(1));
    ctrl.score  = score_i;
    ctrl.cls    = tkss_pkg::INDEX_W'(pos_q);
  end

  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    filled_d    = filled_q;
    remain_d    = remain_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      tkss_pkg::ST_FILL: begin
        if (in_xfer) begin
          if (do_insert) begin
            pos_d    = pos_q + POS_W'(1);
            filled_d = filled_ins;
          end
          if (vector_last_i) begin
            pos_d    = '0;
            filled_d = '0;
            remain_d = CNT_W'(n_ext);
            state_d  = tkss_pkg::ST_DRAIN;
          end
        end
      end
      tkss_pkg::ST_DRAIN: begin
        if (load) begin
          out_valid_d = 1'b1;
          remain_d    = remain_q - CNT_W'(1);
          if (remain_q == CNT_W'(1)) begin
            state_d = tkss_pkg::ST_FILL;
          end
        end
      end
      default: begin
        state_d = tkss_pkg::ST_FILL;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tkss_pkg::ST_FILL;
      pos_q       <= '0;
      filled_q    <= '0;
      remain_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      filled_q    <= filled_d;
      remain_q    <= remain_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_cls_q   <= entry[0].cls;
      out_score_q <= entry[0].score;
      out_last_q  <= (remain_q == CNT_W'(1));
    end
  end

  for (genvar i = 0; i < MAX_K; i++) begin : g_cell
    tkss_pkg::entry_t prev_e, next_e;
    logic             prev_t;

    if (i == 0) begin : g_head
      assign prev_e = '0;
      assign prev_t = 1'b0;
    end else begin : g_body
      assign prev_e = entry[i-1];
      assign prev_t = take[i-1];
    end

    if (i == MAX_K - 1) begin : g_tail
      assign next_e = '0;
    end else begin : g_inner
      assign next_e = entry[i+1];
    end

    tkss_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .prev_i     (prev_e),
      .prev_take_i(prev_t),
      .next_i     (next_e),
      .entry_o    (entry[i]),
      .take_o     (take[i])
    );
  end

  assign out_valid_o   = out_valid_q;
  assign class_index_o = out_cls_q;
  assign class_score_o = out_score_q;
  assign rank_last_o   = out_last_q;

endmodule

FILE: rtl/tkss_checker.sv
`include "assert_macros.svh"

module tkss_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         vector_last_i,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [tkss_pkg::INDEX_W-1:0] class_index_o,
  input logic [tkss_pkg::SCORE_W-1:0] class_score_o,
  input logic                         rank_last_o
);

  // a stalled result holds
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
    out_valid_o && $stable(class_index_o) && $stable(class_score_o) && $stable(rank_last_o))

  // the end of a vector starts a drain that holds off the input
  `ASSERT_NEXT(a_last_drains, clk_i, rst_ni, in_valid_i && !in_stall_o && vector_last_i,
    in_stall_o)

  // the input only closes after the end of a vector
  `ASSERT_NEXT(a_stall_cause, clk_i, rst_ni, !in_stall_o && !(in_valid_i && vector_last_i),
    !in_stall_o)

  // an entry that is not the final one only shows while the drain runs
  `ASSERT_AT(a_mid_in_drain, clk_i, rst_ni, !(out_valid_o && !rank_last_o && !in_stall_o))

endmodule

bind top_k_score_select tkss_checker u_tkss_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .vector_last_i(vector_last_i),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .class_index_o(class_index_o),
  .class_score_o(class_score_o),
  .rank_last_o  (rank_last_o)
);

FILE: tb/top_k_score_select_tb.sv
`timescale 1ns / 100ps

module top_k_score_select_tb;

  localparam int unsigned SCORE_W = tkss_pkg::SCORE_W;
  localparam int unsigned INDEX_W = tkss_pkg::INDEX_W;
  localparam int unsigned TOPK_W  = tkss_pkg::TOPK_W;
  localparam int unsigned PADDR_W = tkss_pkg::PADDR_W;
  localparam int unsigned PDATA_W = tkss_pkg::PDATA_W;

  localparam int unsigned KEEP_MAX = 16;
  localparam int unsigned CHANNELS = 1024;
  localparam logic [PADDR_W-1:0] TOPK_ADDR = PADDR_W'(4 * tkss_pkg::REG_TOP_K);

  typedef struct {
    logic [SCORE_W-1:0] score;
    logic               last;
    int unsigned        pause;
  } score_item_t;

  typedef struct {
    logic [INDEX_W-1:0] cls;
    logic [SCORE_W-1:0] score;
    logic               last;
  } rank_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [SCORE_W-1:0] score_i = '0;
  logic               vector_last_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [INDEX_W-1:0] class_index_o;
  logic [SCORE_W-1:0] class_score_o;
  logic               rank_last_o;

  top_k_score_select #(
    .MAX_K        (KEEP_MAX),
    .MAX_CHANNELS (CHANNELS)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .score_i       (score_i),
    .vector_last_i (vector_last_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .class_index_o (class_index_o),
    .class_score_o (class_score_o),
    .rank_last_o   (rank_last_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // predictor state
  logic [SCORE_W-1:0] kept_score [KEEP_MAX];
  logic [INDEX_W-1:0] kept_cls [KEEP_MAX];
  int unsigned        kept_n = 0;
  int unsigned        next_pos = 0;
  logic [TOPK_W-1:0]  top_k_cfg = tkss_pkg::TOPK_RESET;

  score_item_t score_feed[$];
  rank_t       due_ranks[$];
  score_item_t nxt;
  rank_t       want;

  int unsigned scores_sent = 0;
  int unsigned scores_taken = 0;
  int unsigned ranks_seen = 0;
  int unsigned vectors_done = 0;
  int unsigned mismatches = 0;
  int unsigned idle_run = 0;
  int unsigned hold_left = 0;
  int unsigned hold_pct = 0;

  task automatic report(input string what, input int unsigned got, input int unsigned exp_v);
    mismatches++;
    if (mismatches <= 40)
      $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, exp_v);
  endtask

  function automatic int unsigned pick_pause(input int unsigned pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(30, 8);
    return $urandom_range(3, 1);
  endfunction

  function automatic logic [SCORE_W-1:0] fresh_score(input int unsigned mode);
    case (mode)
      0: return SCORE_W'($urandom);
      1: return SCORE_W'($urandom_range(3));
      2: return $urandom_range(1) ? '1 : '0;
      default: return SCORE_W'($urandom_range(16'hFFFF, 16'hFFF0));
    endcase
  endfunction

  task automatic rank_score(input logic [SCORE_W-1:0] s, input logic last);
    int unsigned p;
    int unsigned j;
    int unsigned k;
    int unsigned n;
    rank_t r;
    if (next_pos < CHANNELS) begin
      p = 0;
      while (p < kept_n && kept_score[p] > s) p++;
      if (p < KEEP_MAX) begin
        j = (kept_n < KEEP_MAX) ? kept_n : KEEP_MAX - 1;
        while (j > p) begin
          kept_score[j] = kept_score[j-1];
          kept_cls[j]   = kept_cls[j-1];
          j--;
        end
        kept_score[p] = s;
        kept_cls[p]   = INDEX_W'(next_pos);
        if (kept_n < KEEP_MAX) kept_n++;
      end
      next_pos++;
    end
    if (last) begin
      k = top_k_cfg;
      if (k == 0) k = 1;
      if (k > KEEP_MAX) k = KEEP_MAX;
      n = (kept_n < k) ? kept_n : k;
      for (int unsigned i = 0; i < n; i++) begin
        r.cls   = kept_cls[i];
        r.score = kept_score[i];
        r.last  = (i + 1 == n);
        due_ranks.insert(due_ranks.size(), r);
      end
      kept_n   = 0;
      next_pos = 0;
      vectors_done++;
    end
  endtask

  // score transfers
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        rank_score(score_i, vector_last_i);
        scores_taken++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (score_feed.size() > 0 && idle_run >= score_feed[0].pause) begin
          nxt = score_feed.pop_front();
          score_i       <= nxt.score;
          vector_last_i <= nxt.last;
          in_valid_i    <= 1'b1;
          idle_run = 0;
        end else begin
          in_valid_i <= 1'b0;
          if (score_feed.size() > 0) idle_run++;
        end
      end
    end
  end

  // result transfers
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        ranks_seen++;
        if (due_ranks.size() == 0) begin
          report("result with nothing due, class_index", class_index_o, 0);
        end else begin
          want = due_ranks.pop_front();
          if (class_index_o !== want.cls) report("class_index", class_index_o, want.cls);
          if (class_score_o !== want.score) report("class_score", class_score_o, want.score);
          if (rank_last_o !== want.last) report("rank_last", rank_last_o, want.last);
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        if ($urandom_range(99) < hold_pct) hold_left = pick_pause(100);
      end
    end
  end

  task automatic push_score(input logic [SCORE_W-1:0] s, input logic last,
                            input int unsigned pause);
    score_item_t it;
    it.score = s;
    it.last  = last;
    it.pause = pause;
    score_feed.insert(score_feed.size(), it);
    scores_sent++;
  endtask

  task automatic wait_idle();
    while (scores_taken != scores_sent || due_ranks.size() != 0) @(negedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_top_k(input logic [TOPK_W-1:0] v);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= TOPK_ADDR;
    pwdata  <= PDATA_W'(v);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    top_k_cfg = v;
    @(posedge clk_i);
    if (pready !== 1'b1) report("pready", pready, 1);
    if (prdata !== PDATA_W'(v)) report("top_k read back", prdata, v);
  endtask

  initial begin
    int unsigned random_sent;
    int unsigned len;
    int unsigned mode;
    int unsigned pct;
    logic [TOPK_W-1:0] k;
    random_sent = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset top_k, ties on the top score, fewer scores than top_k
    hold_pct = 30;
    push_score('0, 1'b0, 0);
    push_score('1, 1'b0, 0);
    push_score('1, 1'b0, 2);
    push_score(16'h8000, 1'b1, 0);
    wait_idle();
    // zero treated as one
    write_top_k('0);
    push_score(16'd1, 1'b0, 0);
    push_score(16'd3, 1'b0, 0);
    push_score(16'd3, 1'b1, 0);
    wait_idle();
    // above the row size, single-score vector
    write_top_k(TOPK_W'(31));
    push_score(16'h5555, 1'b1, 0);
    wait_idle();
    // top_k raised mid-vector
    write_top_k(TOPK_W'(2));
    push_score(16'd100, 1'b0, 0);
    push_score(16'd200, 1'b0, 1);
    push_score(16'hAAAA, 1'b0, 0);
    wait_idle();
    write_top_k(TOPK_W'(16));
    push_score(16'd50, 1'b0, 0);
    push_score('0, 1'b1, 0);
    wait_idle();
    // top_k lowered mid-vector
    write_top_k(TOPK_W'(3));
    push_score(16'd20, 1'b0, 0);
    push_score(16'd10, 1'b0, 0);
    wait_idle();
    write_top_k(TOPK_W'(1));
    push_score(16'd30, 1'b1, 0);
    wait_idle();
    write_top_k(TOPK_W'(17));
    push_score(16'd7, 1'b0, 0);
    push_score(16'd9, 1'b0, 0);
    push_score(16'd9, 1'b0, 0);
    push_score(16'd1, 1'b1, 0);
    wait_idle();

    while (random_sent < 175) begin
      case ($urandom_range(7))
        0: k = '0;
        1: k = TOPK_W'(1);
        2: k = TOPK_W'(16);
        3: k = '1;
        default: k = TOPK_W'($urandom_range(31));
      endcase
      write_top_k(k);
      case ($urandom_range(2))
        0: hold_pct = 0;
        1: hold_pct = 15;
        default: hold_pct = 40;
      endcase
      repeat ($urandom_range(4, 1)) begin
        len  = ($urandom_range(5) == 0) ? 1 : $urandom_range(20, 1);
        mode = $urandom_range(5);
        if (mode > 3) mode = 0;
        case ($urandom_range(2))
          0: pct = 0;
          1: pct = 20;
          default: pct = 50;
        endcase
        for (int unsigned i = 0; i < len; i++)
          push_score(fresh_score(mode), i == len - 1, pick_pause(pct));
        random_sent += len;
      end
      wait_idle();
    end

    repeat (10) @(posedge clk_i);
    $display("Covered %0d score vectors, %0d score transfers, %0d ranked entries checked;",
             vectors_done, scores_taken, ranks_seen);
    $display("top_k swept over zero, one, sixteen and beyond, incl. changes mid-vector.");
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/tkss_pkg.sv
rtl/tkss_cell.sv
rtl/top_k_score_select.sv
rtl/tkss_checker.sv
tb/top_k_score_select_tb.sv
